FILE: rtl/fqs_pkg.sv
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int INDEX_W        = 5;
    localparam int REQ_W          = 2;
    localparam int STATUS_W       = 2;

    localparam logic [INDEX_W-1:0] NOT_FOUND = {INDEX_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_CLR  = 2'd2,
        REQ_FIND = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SEARCH,
        S_EMIT
    } state_t;

endpackage

FILE: rtl/fqs_if.sv
`timescale 1ns / 1ps

interface fqs_req_if;
    logic                        valid;
    logic                        ready;
    logic [fqs_pkg::REQ_W-1:0]   req_type;
    logic [fqs_pkg::VALUE_W-1:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface fqs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fqs_pkg::VALUE_W-1:0]        out_value;
    logic signed [fqs_pkg::INDEX_W-1:0] found_index;
    logic                               queue_empty;
    logic [fqs_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output out_value, output found_index,
                    output queue_empty, output status, input ready);
    modport sink   (input valid, input out_value, input found_index,
                    input queue_empty, input status, output ready);
endinterface

FILE: rtl/fifo_queue_with_search.sv
`timescale 1ns / 1ps

// Queue of DEPTH words in a ring memory with separate write and read ports and
// registered reads, one request at a time, one result per request. Enqueue,
// clear and a refused dequeue go straight to the emit state, a dequeue that
// returns a word passes through a state that takes the read word, and an
// index-of search compares m entries, where m is the match position + 1, or the
// entry count if there is no match; 0 on an empty queue: the memory read port
// delivers one stored entry per cycle. The emit state loads the output register
// and waits while that register still holds a result the sink has not taken.
// A new request is taken while the previous result still waits in it.
module fifo_queue_with_search #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    fqs_req_if.sink  req,
    fqs_rsp_if.source rsp
);
    import fqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    state_t                state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         off_reg, off_next;
    logic [AW-1:0]         rp_reg, rp_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic [INDEX_W-1:0]    res_found_reg, res_found_next;
    status_t               res_status_reg, res_status_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [INDEX_W-1:0]    out_found_reg, out_found_next;
    logic                  out_empty_reg, out_empty_next;
    status_t               out_status_reg, out_status_next;

    logic [63:0]           item_wide;
    logic [63:0]           rd_wide;
    logic [DATA_WIDTH-1:0] item_val;
    logic [AW:0]           tail_sum;
    logic [AW-1:0]         tail_ptr;
    logic [AW-1:0]         front_inc;
    logic [AW-1:0]         rp_inc;
    logic [31:0]           off_ext;
    logic                  accept;

    assign item_wide = {32'b0, req.item_value};
    assign item_val  = item_wide[DATA_WIDTH-1:0];
    assign rd_wide   = 64'(rd_data_reg);
    assign off_ext   = 32'(off_reg);
    assign tail_sum  = (AW + 1)'(front_reg) + (AW + 1)'(count_reg);
    assign tail_ptr  = (tail_sum >= (AW + 1)'(DEPTH)) ?
                       AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign rp_inc    = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;

    assign req.ready       = (state_reg == S_IDLE);
    assign accept          = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.found_index = out_found_reg;
    assign rsp.queue_empty = out_empty_reg;
    assign rsp.status      = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= item_val;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        rp_next         = rp_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_ptr;
        mem_re          = 1'b0;
        mem_raddr       = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_found_next  = NOT_FOUND;
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                    case (req_t'(req.req_type))
                        REQ_ENQ:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                                state_next = S_DEQ;
                            end
                        end
                        REQ_CLR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            key_next = item_val;
                            off_next = '0;
                            rp_next  = front_inc;
                            if (count_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                state_next = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                res_value_next = rd_wide[VALUE_W-1:0];
                state_next     = S_EMIT;
            end
            S_SEARCH:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_found_next = off_ext[INDEX_W-1:0];
                    state_next     = S_EMIT;
                end
                else if (CW'(off_reg) + 1'b1 == count_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rp_reg;
                    rp_next   = rp_inc;
                    off_next  = off_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_found_next  = res_found_reg;
                    out_empty_next  = (count_reg == '0);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        rp_reg         <= rp_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

endmodule

FILE: rtl/fqs_checker.sv
`timescale 1ns / 1ps

module fqs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [fqs_pkg::VALUE_W-1:0]        out_value,
    input logic [fqs_pkg::INDEX_W-1:0]        found_index,
    input logic                               queue_empty,
    input logic [fqs_pkg::STATUS_W-1:0]       status
);
    import fqs_pkg::*;

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> !queue_empty && out_value == '0)
        else $error("full status with empty queue or nonzero value");

    a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> queue_empty && out_value == '0)
        else $error("refused dequeue on a non-empty queue");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_index != NOT_FOUND
        |-> status == ST_OK && !queue_empty && out_value == '0)
        else $error("search hit with inconsistent result fields");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous request in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
        && $stable(found_index) && $stable(queue_empty) && $stable(status))
        else $error("stalled result changed");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_value   (rsp.out_value),
    .found_index (rsp.found_index),
    .queue_empty (rsp.queue_empty),
    .status      (rsp.status)
);
